// File: rtl/two_band_link_arbiter_defines.svh
// ----------------------------------------------------------------------------
// Two-band link arbiter: assertion macros
// Shared property forms for the checker; clk and rst_n are taken from scope.
// ----------------------------------------------------------------------------
`ifndef TWO_BAND_LINK_ARBITER_DEFINES_SVH
`define TWO_BAND_LINK_ARBITER_DEFINES_SVH

// same-cycle implication
`define TBLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tbla_pkg.sv
// ----------------------------------------------------------------------------
// Two-band link arbiter: package
// Widths, codes, request and result types, queue pointer helpers.
// ----------------------------------------------------------------------------
package tbla_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int TAG_W     = 16;
  localparam int SIZE_W    = 32;
  localparam int TIME_W    = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int RATIO_W   = 9;
  localparam int SCALE_W   = 12;
  localparam int FACT_W    = RATIO_W + SCALE_W;
  localparam int FACT_DIG  = (FACT_W + 1) / 2;
  localparam int MR_W      = 2 * FACT_DIG;
  localparam int MAC_W     = SIZE_W + FACT_W;
  localparam int FRAC_W    = 8;
  localparam int CNT_W     = $clog2(SIZE_W);

  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [SIZE_W-1:0]  CAP_RST   = SIZE_W'(1);
  localparam logic [SIZE_W-1:0]  SMALL_RST = SIZE_W'(1024);
  localparam logic [RATIO_W-1:0] RATIO_RST = '0;
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1);

  localparam logic [1:0] MODE_SEIZE_TO_MASTER     = 2'd0;
  localparam logic [1:0] MODE_SEIZE_FROM_MASTER   = 2'd1;
  localparam logic [1:0] MODE_RELEASE_TO_MASTER   = 2'd2;
  localparam logic [1:0] MODE_RELEASE_FROM_MASTER = 2'd3;

  localparam logic [1:0] KIND_GRANT      = 2'd0;
  localparam logic [1:0] KIND_FWD_MASTER = 2'd1;
  localparam logic [1:0] KIND_FWD_WORKER = 2'd2;
  localparam logic [1:0] KIND_DROPPED    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_RATIO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SCALE  = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TAG_W-1:0]  request_tag;
    logic [SIZE_W-1:0] transfer_size;
    logic [TIME_W-1:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [TAG_W-1:0]  out_tag;
    logic [SIZE_W-1:0] out_size;
    logic              toward_master;
    logic [TIME_W-1:0] out_time;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic              to_master;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_DIV,
    ST_PREP,
    ST_MUL,
    ST_ADD
  } state_t;

  localparam logic [QA_W:0] DEPTH_V = (QA_W + 1)'(QUEUE_DEPTH);

  function automatic logic [QA_W-1:0] q_tail(input logic [QA_W-1:0] head,
                                             input logic [QC_W-1:0] cnt);
    logic [QA_W:0] s;
    s = {1'b0, head} + (QA_W + 1)'(cnt);
    if (s >= DEPTH_V) begin
      s = s - DEPTH_V;
    end
    return s[QA_W-1:0];
  endfunction

  function automatic logic [QA_W-1:0] q_next(input logic [QA_W-1:0] head);
    logic [QA_W:0] s;
    s = {1'b0, head} + (QA_W + 1)'(1);
    if (s >= DEPTH_V) begin
      s = '0;
    end
    return s[QA_W-1:0];
  endfunction

endpackage

// File: rtl/tbla_ram.sv
// ----------------------------------------------------------------------------
// Two-band link arbiter: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tbla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/two_band_link_arbiter.sv
// ----------------------------------------------------------------------------
// Two-band link arbiter
// Single-transfer link with high and low priority FIFOs for waiting seizes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each result is shown
// on out_data for exactly one cycle with out_strobe high and cannot be held
// off, so the receiver must take it then; last_result marks the final result
// of a request. A seize that is queued or dropped, or a release with nothing
// waiting, keeps busy high only while it is decoded. A grant passes from accept
// to result through decode (and load, when it follows a release, whose forward
// result comes out first), the bit-serial divider for size / capacity, one
// quotient bit per cycle, prep, the radix-4 serial multiplier for the extra
// delay, and the final add. Configuration writes take effect on the next cycle.
module two_band_link_arbiter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  tbla_pkg::in_item_t                  in_data,
  output logic                                out_strobe,
  output tbla_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [tbla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbla_pkg::CFG_W-1:0]          cfg_data
);

  import tbla_pkg::*;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  cap_r;
  logic [SIZE_W-1:0]  small_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [SCALE_W-1:0] scale_r;

  in_item_t item_r, item_nxt;

  logic            link_busy_r, link_busy_nxt;
  logic [QA_W-1:0] hi_head_r, hi_head_nxt, lo_head_r, lo_head_nxt;
  logic [QC_W-1:0] hi_cnt_r, hi_cnt_nxt, lo_cnt_r, lo_cnt_nxt;
  logic            pop_hi_r, pop_hi_nxt;

  slot_t             grant_r, grant_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] dq_r, dq_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SIZE_W+1:0] b3_r, b3_nxt;
  logic [MR_W-1:0]   mr_r, mr_nxt;
  logic [MAC_W-1:0]  acc_r, acc_nxt;
  logic [TIME_W:0]   t_r, t_nxt;

  logic      out_strobe_r, out_strobe_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic            hi_we, lo_we;
  logic [QA_W-1:0] hi_waddr, lo_waddr;
  slot_t           hi_rdata, lo_rdata, new_slot, pop_slot;

  logic [SIZE_W-1:0] cap_eff;
  logic [SIZE_W+1:0] diff;
  logic              ge;
  logic [SIZE_W+1:0] addend;
  logic [TIME_W+1:0] sum;

  tbla_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_hi_ram (
    .clk   (clk),
    .we    (hi_we),
    .waddr (hi_waddr),
    .wdata (new_slot),
    .raddr (hi_head_r),
    .rdata (hi_rdata)
  );

  tbla_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_lo_ram (
    .clk   (clk),
    .we    (lo_we),
    .waddr (lo_waddr),
    .wdata (new_slot),
    .raddr (lo_head_r),
    .rdata (lo_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RST;
      small_r <= SMALL_RST;
      ratio_r <= RATIO_RST;
      scale_r <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY:    cap_r   <= cfg_data;
        CFG_SMALL_LIMIT: small_r <= cfg_data;
        CFG_DELAY_RATIO: ratio_r <= cfg_data[RATIO_W-1:0];
        CFG_UNIT_SCALE:  scale_r <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      link_busy_r  <= 1'b0;
      hi_head_r    <= '0;
      hi_cnt_r     <= '0;
      lo_head_r    <= '0;
      lo_cnt_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      link_busy_r  <= link_busy_nxt;
      hi_head_r    <= hi_head_nxt;
      hi_cnt_r     <= hi_cnt_nxt;
      lo_head_r    <= lo_head_nxt;
      lo_cnt_r     <= lo_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pop_hi_r   <= pop_hi_nxt;
    grant_r    <= grant_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    cnt_r      <= cnt_nxt;
    b3_r       <= b3_nxt;
    mr_r       <= mr_nxt;
    acc_r      <= acc_nxt;
    t_r        <= t_nxt;
    out_data_r <= out_data_nxt;
  end

  // serial datapath terms
  always_comb begin
    cap_eff = (cap_r == '0) ? SIZE_W'(1) : cap_r;
    diff    = {1'b0, rem_r, dq_r[SIZE_W-1]} - {2'b00, cap_eff};
    ge      = !diff[SIZE_W+1];
    case (mr_r[MR_W-1:MR_W-2])
      2'd0:    addend = '0;
      2'd1:    addend = (SIZE_W + 2)'(dq_r);
      2'd2:    addend = {1'b0, dq_r, 1'b0};
      default: addend = b3_r;
    endcase
    sum = {1'b0, t_r} + (TIME_W + 2)'(acc_r[MAC_W-1:FRAC_W]);
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    link_busy_nxt  = link_busy_r;
    hi_head_nxt    = hi_head_r;
    hi_cnt_nxt     = hi_cnt_r;
    lo_head_nxt    = lo_head_r;
    lo_cnt_nxt     = lo_cnt_r;
    pop_hi_nxt     = pop_hi_r;
    grant_nxt      = grant_r;
    rem_nxt        = rem_r;
    dq_nxt         = dq_r;
    cnt_nxt        = cnt_r;
    b3_nxt         = b3_r;
    mr_nxt         = mr_r;
    acc_nxt        = acc_r;
    t_nxt          = t_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    hi_we          = 1'b0;
    lo_we          = 1'b0;
    hi_waddr       = q_tail(hi_head_r, hi_cnt_r);
    lo_waddr       = q_tail(lo_head_r, lo_cnt_r);
    new_slot.tag       = item_r.request_tag;
    new_slot.size      = item_r.transfer_size;
    new_slot.to_master = (item_r.mode == MODE_SEIZE_TO_MASTER);
    pop_slot       = pop_hi_r ? hi_rdata : lo_rdata;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (item_r.mode == MODE_SEIZE_TO_MASTER || item_r.mode == MODE_SEIZE_FROM_MASTER) begin
          if (!link_busy_r) begin
            link_busy_nxt = 1'b1;
            grant_nxt     = new_slot;
            dq_nxt        = new_slot.size;
            rem_nxt       = '0;
            cnt_nxt       = '0;
            state_nxt     = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
            if ((item_r.transfer_size <= small_r && hi_cnt_r == QC_W'(QUEUE_DEPTH)) ||
                (item_r.transfer_size >  small_r && lo_cnt_r == QC_W'(QUEUE_DEPTH))) begin
              out_strobe_nxt             = 1'b1;
              out_data_nxt.result_kind   = KIND_DROPPED;
              out_data_nxt.out_tag       = new_slot.tag;
              out_data_nxt.out_size      = new_slot.size;
              out_data_nxt.toward_master = new_slot.to_master;
              out_data_nxt.out_time      = item_r.event_time;
              out_data_nxt.last_result   = 1'b1;
            end else if (item_r.transfer_size <= small_r) begin
              hi_we      = 1'b1;
              hi_cnt_nxt = hi_cnt_r + QC_W'(1);
            end else begin
              lo_we      = 1'b1;
              lo_cnt_nxt = lo_cnt_r + QC_W'(1);
            end
          end
        end else begin
          // release: forward now, head request read from the RAM meanwhile
          out_strobe_nxt             = 1'b1;
          out_data_nxt.result_kind   = (item_r.mode == MODE_RELEASE_TO_MASTER) ?
                                       KIND_FWD_MASTER : KIND_FWD_WORKER;
          out_data_nxt.out_tag       = item_r.request_tag;
          out_data_nxt.out_size      = item_r.transfer_size;
          out_data_nxt.toward_master = (item_r.mode == MODE_RELEASE_TO_MASTER);
          out_data_nxt.out_time      = item_r.event_time;
          out_data_nxt.last_result   = (hi_cnt_r == '0) && (lo_cnt_r == '0);
          if (hi_cnt_r != '0) begin
            pop_hi_nxt    = 1'b1;
            hi_head_nxt   = q_next(hi_head_r);
            hi_cnt_nxt    = hi_cnt_r - QC_W'(1);
            link_busy_nxt = 1'b1;
            state_nxt     = ST_LOAD;
          end else if (lo_cnt_r != '0) begin
            pop_hi_nxt    = 1'b0;
            lo_head_nxt   = q_next(lo_head_r);
            lo_cnt_nxt    = lo_cnt_r - QC_W'(1);
            link_busy_nxt = 1'b1;
            state_nxt     = ST_LOAD;
          end else begin
            link_busy_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end

      ST_LOAD: begin
        grant_nxt = pop_slot;
        dq_nxt    = pop_slot.size;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end

      // restoring division, one quotient bit per cycle
      ST_DIV: begin
        rem_nxt = ge ? diff[SIZE_W-1:0] : {rem_r[SIZE_W-2:0], dq_r[SIZE_W-1]};
        dq_nxt  = {dq_r[SIZE_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SIZE_W - 1)) begin
          state_nxt = ST_PREP;
        end
      end

      ST_PREP: begin
        b3_nxt    = (SIZE_W + 2)'(dq_r) + {1'b0, dq_r, 1'b0};
        mr_nxt    = MR_W'(FACT_W'(ratio_r) * FACT_W'(scale_r));
        acc_nxt   = '0;
        t_nxt     = (TIME_W + 1)'(item_r.event_time) + (TIME_W + 1)'(dq_r);
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end

      // radix-4 shift-and-add, top digit first
      ST_MUL: begin
        acc_nxt = {acc_r[MAC_W-3:0], 2'b00} + MAC_W'(addend);
        mr_nxt  = {mr_r[MR_W-3:0], 2'b00};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FACT_DIG - 1)) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        out_strobe_nxt             = 1'b1;
        out_data_nxt.result_kind   = KIND_GRANT;
        out_data_nxt.out_tag       = grant_r.tag;
        out_data_nxt.out_size      = grant_r.size;
        out_data_nxt.toward_master = grant_r.to_master;
        out_data_nxt.out_time      = (sum[TIME_W+1:TIME_W] != 2'b00) ?
                                     TIME_MAX : sum[TIME_W-1:0];
        out_data_nxt.last_result   = 1'b1;
        state_nxt                  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// File: rtl/tbla_checker.sv
// ----------------------------------------------------------------------------
// Two-band link arbiter: port checker
// Request and result sequencing as seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "two_band_link_arbiter_defines.svh"

module tbla_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input tbla_pkg::out_item_t out_data
);

  import tbla_pkg::*;

  logic accepted;

  assign accepted = start && !busy;

  `TBLA_ASSERT_NEXT(a_busy_after_req, accepted, busy, "busy low after request taken")
  `TBLA_ASSERT_NEXT(a_no_early_result, accepted, !out_strobe, "result in cycle after request")
  `TBLA_ASSERT_NOW(a_more_pending, out_strobe && !out_data.last_result, busy, "idle mid request")
  `TBLA_ASSERT_NOW(a_last_idle, out_strobe && out_data.last_result, !busy, "busy at final result")

endmodule

bind two_band_link_arbiter tbla_checker u_tbla_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
